@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define WDLP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define WDLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/wdlp_pkg.sv @@
// package with types, codes and header constants for the wave data length parser
`default_nettype none

package wdlp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CHUNK  = 3'd1,
    PH_SKIP   = 3'd2,
    PH_DONE   = 3'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADHDR = 2'd1,
    ST_NODATA = 2'd2
  } status_t;

  localparam logic [3:0]  HEADER_LAST    = 4'd11;
  localparam logic [3:0]  CHUNK_HDR_LAST = 4'd7;
  localparam logic [3:0]  TAG_BYTES      = 4'd4;
  localparam logic [31:0] TAG_DATA       = 32'h6461_7461;

  typedef struct packed {
    logic         valid;
    logic [29:0]  frames;
    status_t      status;
  } result_t;

  // expected byte at a checked header position
  function automatic logic [7:0] hdr_expect(input logic [3:0] pos);
    logic [7:0] val;
    val = 8'h00;
    unique case (pos)
      4'd0:    val = 8'h52;
      4'd1:    val = 8'h49;
      4'd2:    val = 8'h46;
      4'd3:    val = 8'h46;
      4'd8:    val = 8'h57;
      4'd9:    val = 8'h41;
      4'd10:   val = 8'h56;
      4'd11:   val = 8'h45;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic logic hdr_checked(input logic [3:0] pos);
    return (pos < 4'd4) || ((pos >= 4'd8) && (pos <= HEADER_LAST));
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wdlp_parser.sv @@
// per-byte parser state and result decision
`default_nettype none
`include "assert_macros.svh"

module wdlp_parser
  import wdlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  byte_value,
  input  wire logic        end_of_file,
  output result_t          res
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        mismatch_r, mismatch_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] skip_r, skip_nxt;

  logic [31:0] tag_upd;
  logic [31:0] size_upd;
  logic        mism_upd;
  logic [31:0] skip_dec;

  always_comb begin
    tag_upd  = (pos_r < TAG_BYTES) ? {tag_r[23:0], byte_value} : tag_r;
    size_upd = (pos_r < TAG_BYTES) ? size_r
             : (size_r | ({24'd0, byte_value} << {pos_r[1:0], 3'b000}));
    mism_upd = mismatch_r |
               (hdr_checked(pos_r) && (byte_value != hdr_expect(pos_r)));
    skip_dec = (skip_r != 32'd0) ? (skip_r - 32'd1) : skip_r;

    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    mismatch_nxt = mismatch_r;
    tag_nxt      = tag_r;
    size_nxt     = size_r;
    skip_nxt     = skip_r;
    res.valid    = 1'b0;
    res.frames   = 30'd0;
    res.status   = ST_OK;

    unique case (phase_r)
      PH_HEADER: begin
        mismatch_nxt = mism_upd;
        if (pos_r >= HEADER_LAST) begin
          if (mism_upd) begin
            res.valid  = 1'b1;
            res.status = ST_BADHDR;
            phase_nxt  = PH_DONE;
          end else begin
            phase_nxt = PH_CHUNK;
            pos_nxt   = 4'd0;
            tag_nxt   = 32'd0;
            size_nxt  = 32'd0;
            if (end_of_file) begin
              res.valid  = 1'b1;
              res.status = ST_NODATA;
            end
          end
        end else begin
          pos_nxt = pos_r + 4'd1;
          if (end_of_file) begin
            res.valid  = 1'b1;
            res.status = ST_BADHDR;
          end
        end
      end
      PH_CHUNK: begin
        tag_nxt  = tag_upd;
        size_nxt = size_upd;
        if (pos_r >= CHUNK_HDR_LAST) begin
          pos_nxt = 4'd0;
          if (tag_upd == TAG_DATA) begin
            res.valid  = 1'b1;
            res.frames = size_upd[31:2];
            res.status = ST_OK;
            phase_nxt  = PH_DONE;
          end else begin
            if (size_upd != 32'd0) begin
              skip_nxt  = size_upd;
              phase_nxt = PH_SKIP;
            end
            tag_nxt  = 32'd0;
            size_nxt = 32'd0;
            if (end_of_file) begin
              res.valid  = 1'b1;
              res.status = ST_NODATA;
            end
          end
        end else begin
          pos_nxt = pos_r + 4'd1;
          if (end_of_file) begin
            res.valid  = 1'b1;
            res.status = ST_NODATA;
          end
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_nxt = PH_CHUNK;
          pos_nxt   = 4'd0;
          tag_nxt   = 32'd0;
          size_nxt  = 32'd0;
        end
        if (end_of_file) begin
          res.valid  = 1'b1;
          res.status = ST_NODATA;
        end
      end
      default: begin
        // result given, wait for end of file
      end
    endcase

    if (end_of_file) begin
      phase_nxt    = PH_HEADER;
      pos_nxt      = 4'd0;
      mismatch_nxt = 1'b0;
      tag_nxt      = 32'd0;
      size_nxt     = 32'd0;
      skip_nxt     = 32'd0;
    end

    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pos_r      <= 4'd0;
      mismatch_r <= 1'b0;
      tag_r      <= 32'd0;
      size_r     <= 32'd0;
      skip_r     <= 32'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      mismatch_r <= mismatch_nxt;
      tag_r      <= tag_nxt;
      size_r     <= size_nxt;
      skip_r     <= skip_nxt;
    end
  end

  `WDLP_ASSERT(a_fail_zero_frames, clk, rst_n,
    (res.valid && (res.status != ST_OK)) |-> (res.frames == 30'd0), "frames nonzero on failure")
  `WDLP_ASSERT(a_done_silent, clk, rst_n,
    (step && (phase_r == PH_DONE)) |-> !res.valid, "second result in one file")
  `WDLP_ASSERT(a_eof_restart, clk, rst_n,
    (step && end_of_file) |=> ((phase_r == PH_HEADER) && (pos_r == 4'd0)), "no restart on eof")

endmodule

`default_nettype wire

@@ hw/rtl/wdlp_out_reg.sv @@
// result register between parser and output stream
`default_nettype none
`include "assert_macros.svh"

module wdlp_out_reg
  import wdlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire result_t     res,
  output logic             in_ready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata
);

  logic        valid_r;
  logic [29:0] frames_r;
  status_t     status_r;

  assign in_ready   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {status_r, frames_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.valid) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      frames_r <= res.frames;
      status_r <= res.status;
    end
  end

  `WDLP_ASSERT_ALWAYS(a_reset_empty, clk,
    !rst_n |=> !valid_r, "result register not cleared by reset")
  `WDLP_ASSERT(a_push_shows, clk, rst_n,
    res.valid |=> valid_r, "pushed result not presented")
  `WDLP_ASSERT(a_stall_only_full, clk, rst_n,
    !in_ready |-> (valid_r && !out_tready), "input stalled without a waiting result")

endmodule

`default_nettype wire

@@ hw/rtl/wav_data_length_parser.sv @@
// top level of the wave file data length parser
// a result appears on out_tvalid in the cycle after the deciding byte is accepted
// throughput: one byte per cycle while the result side keeps up
// in_tready drops only while a result waits and out_tready is low
// rst_n (synchronous, active low) returns the parser to the file header and empties the result
`default_nettype none

module wav_data_length_parser
  import wdlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // byte_value
  input  wire logic        in_tlast,   // end_of_file
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // duration_frames[29:0], status[31:30]
);

  logic    step;
  result_t res;

  assign step = in_tvalid && in_tready;

  wdlp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .byte_value  (in_tdata),
    .end_of_file (in_tlast),
    .res         (res)
  );

  wdlp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .in_ready   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
